FILE: design/stsp_pkg.sv
// ----------------------------------------------------------------------------
// stsp_pkg
// Shared types and constants for the stepper trapezoid speed-profile unit.
// ----------------------------------------------------------------------------
package stsp_pkg;

    localparam int DIV_DW = 50;   // dividend magnitude width
    localparam int DIV_VW = 33;   // divisor magnitude width

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_ANGLE = 2'd1;
    localparam logic [1:0] MODE_TURN  = 2'd2;
    localparam logic [1:0] MODE_STOP  = 2'd3;

    localparam logic [1:0] DIR_CW   = 2'b01;
    localparam logic [1:0] DIR_NEAR = 2'b00;
    localparam logic [1:0] DIR_CCW  = 2'b11;
    localparam logic [1:0] DIR_NONE = 2'b10;

    localparam logic [2:0] REG_STEPS    = 3'd0;
    localparam logic [2:0] REG_RAMP_IN  = 3'd1;
    localparam logic [2:0] REG_RAMP_OUT = 3'd2;
    localparam logic [2:0] REG_PEAK     = 3'd3;
    localparam logic [2:0] REG_CONST    = 3'd4;
    localparam logic [2:0] REG_FIXED    = 3'd5;
    localparam logic [2:0] REG_TOP      = 3'd6;
    localparam logic [2:0] REG_FLOOR    = 3'd7;

    typedef struct packed {
        logic [15:0] steps_per_turn;
        logic [8:0]  ramp_in_fraction;
        logic [8:0]  ramp_out_fraction;
        logic [8:0]  peak_limit;
        logic        constant_mode;
        logic [15:0] fixed_speed;
        logic [15:0] top_speed;
        logic [15:0] floor_speed;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ANG_DIV,
        S_ANG_WAIT,
        S_GMUL,
        S_GOAL,
        S_RMUL,
        S_RAMP,
        S_SEL,
        S_MMUL,
        S_MAP_DIV,
        S_MAP_WAIT,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_sel;     // 0: angle division, 1: ramp interpolation
        logic ang_save;
        logic gmul;
        logic goal;
        logic rmul;
        logic ramp;
        logic sel;
        logic mmul;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic out_full;
    } t_sts;

endpackage

FILE: design/stsp_divider.sv
// ----------------------------------------------------------------------------
// stsp_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stsp_divider #(
    parameter int DW = 50,
    parameter int VW = 33
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_busy,
    output logic [DW-1:0] o_quotient,
    output logic [VW-1:0] o_remainder
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_q, n_q;
    logic [VW-1:0] r_rem, n_rem;
    logic [VW-1:0] r_d;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [VW:0]   w_sh;
    logic [VW:0]   w_diff;

    always_comb begin
        w_sh   = {r_rem, r_q[DW-1]};
        w_diff = w_sh - {1'b0, r_d};
        if (!w_diff[VW]) begin
            n_rem = w_diff[VW-1:0];
            n_q   = {r_q[DW-2:0], 1'b1};
        end else begin
            n_rem = w_sh[VW-1:0];
            n_q   = {r_q[DW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DW);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_busy      = r_busy;
    assign o_quotient  = r_q;
    assign o_remainder = r_rem;

endmodule

FILE: design/stsp_datapath.sv
// ----------------------------------------------------------------------------
// stsp_datapath
// Move state, goal and ramp arithmetic, interpolation and the result register.
// ----------------------------------------------------------------------------
module stsp_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  stsp_pkg::t_cfg        i_cfg,
    input  stsp_pkg::t_cmd        i_cmd,
    output stsp_pkg::t_sts        o_sts,
    input  logic [1:0]            i_mode,
    input  logic signed [31:0]    i_current_position,
    input  logic [15:0]           i_target_angle,
    input  logic signed [1:0]     i_turn_direction,
    input  logic [15:0]           i_turn_count,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [15:0]           o_speed,
    output logic signed [31:0]    o_goal_position,
    output logic                  o_moving,
    output logic [15:0]           o_angle_in_turn
);
    import stsp_pkg::*;

    logic [15:0]        w_s;
    logic [1:0]         r_mode;
    logic signed [31:0] r_cur;
    logic [15:0]        r_tgt;
    logic [1:0]         r_dir;
    logic [15:0]        r_turns;

    logic signed [31:0] r_start, r_end, r_len;
    logic               r_halted;
    logic [15:0]        r_angle;
    logic [31:0]        r_gprod;
    logic signed [40:0] r_pin_p, r_pout_p;
    logic [16:0]        r_peak;
    logic signed [31:0] r_pin, r_pout;
    logic signed [32:0] r_dx, r_db;
    logic signed [17:0] r_dy;
    logic [16:0]        r_ya, r_yb;
    logic               r_flat;
    logic signed [50:0] r_prod;
    logic               r_out_valid;

    // divider hookup
    logic [31:0]        w_cur_mag;
    logic [50:0]        w_prod_mag;
    logic [32:0]        w_db_mag;
    logic [DIV_DW-1:0]  w_dvd;
    logic [DIV_VW-1:0]  w_dvs;
    logic [DIV_DW-1:0]  w_quo;
    logic [DIV_VW-1:0]  w_rem;
    logic               w_busy;

    assign w_s        = (i_cfg.steps_per_turn == 16'd0) ? 16'd1 : i_cfg.steps_per_turn;
    assign w_cur_mag  = r_cur[31] ? 32'(-r_cur) : 32'(r_cur);
    assign w_prod_mag = r_prod[50] ? 51'(-r_prod) : 51'(r_prod);
    assign w_db_mag   = r_db[32] ? 33'(-r_db) : 33'(r_db);

    always_comb begin
        if (i_cmd.div_sel) begin
            w_dvd = w_prod_mag[DIV_DW-1:0];
            w_dvs = w_db_mag;
        end else begin
            w_dvd = {{(DIV_DW-32){1'b0}}, w_cur_mag};
            w_dvs = {{(DIV_VW-16){1'b0}}, w_s};
        end
    end

    stsp_divider #(.DW(DIV_DW), .VW(DIV_VW)) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (w_dvd),
        .i_divisor   (w_dvs),
        .o_busy      (w_busy),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    // goal of a move
    logic signed [17:0] w_dist;
    logic [31:0]        w_dist32, w_s32, w_base, w_goal;
    logic [40:0]        w_tnum;
    logic               w_tround;

    always_comb begin
        w_dist   = $signed({2'b00, r_tgt}) - $signed({2'b00, r_angle});
        w_dist32 = {{14{w_dist[17]}}, w_dist};
        w_s32    = {16'd0, w_s};
        w_base   = r_cur + w_dist32;
        w_tnum   = {r_cur[31], r_cur, 8'd0};
        if (r_dir == DIR_CW) begin
            w_tnum = w_tnum + {9'd0, r_gprod};
        end else begin
            w_tnum = w_tnum - {9'd0, r_gprod};
        end
        // truncate toward zero
        w_tround = w_tnum[40] && (w_tnum[7:0] != 8'd0);
        w_goal   = r_cur;
        if (r_mode == MODE_ANGLE) begin
            unique case (r_dir)
                DIR_CCW:  w_goal = w_base - r_gprod - (w_dist[17] ? 32'd0 : w_s32);
                DIR_NEAR: w_goal = w_dist[17] ? w_base - r_gprod : w_base + r_gprod;
                DIR_CW:   w_goal = w_base + r_gprod + (w_dist[17] ? w_s32 : 32'd0);
                default:  w_goal = r_cur;
            endcase
        end else if (r_dir == DIR_CW || r_dir == DIR_CCW) begin
            w_goal = w_tnum[39:8] + {31'd0, w_tround};
        end
    end

    // ramp boundaries
    logic [42:0] w_pin_n, w_pout_n;
    logic [31:0] w_pin, w_pout;

    always_comb begin
        w_pin_n  = {{2{r_start[31]}}, r_start, 9'd0} + {{2{r_pin_p[40]}}, r_pin_p};
        w_pout_n = {{2{r_end[31]}}, r_end, 9'd0} - {{2{r_pout_p[40]}}, r_pout_p};
        w_pin    = w_pin_n[40:9] + {31'd0, w_pin_n[42] && (w_pin_n[8:0] != 9'd0)};
        w_pout   = w_pout_n[40:9] + {31'd0, w_pout_n[42] && (w_pout_n[8:0] != 9'd0)};
    end

    // segment selection
    logic               w_desc, w_in_seg, w_out_seg;
    logic signed [31:0] w_a, w_b;
    logic [16:0]        w_ya, w_yb;
    logic [16:0]        w_lo;

    always_comb begin
        w_lo      = {1'b0, i_cfg.floor_speed};
        w_desc    = r_start > r_end;
        w_in_seg  = w_desc ? (r_cur >= r_pin) : (r_cur <= r_pin);
        w_out_seg = w_desc ? (r_cur <= r_pout) : (r_cur >= r_pout);
        if (w_in_seg) begin
            w_a = r_start; w_b = r_pin;  w_ya = w_lo;   w_yb = r_peak;
        end else begin
            w_a = r_pout;  w_b = r_end;  w_ya = r_peak; w_yb = w_lo;
        end
    end

    // final speed
    logic [50:0]        w_qmag;
    logic signed [50:0] w_qs, w_v;
    logic [15:0]        w_speed;

    always_comb begin
        w_qmag = {1'b0, w_quo};
        w_qs   = (r_prod[50] ^ r_db[32]) ? -$signed(w_qmag) : $signed(w_qmag);
        if (r_flat) begin
            w_v = $signed({34'd0, r_peak});
        end else if (r_db == 33'sd0) begin
            w_v = $signed({34'd0, r_yb});
        end else begin
            w_v = w_qs + $signed({34'd0, r_ya});
        end
        if (r_halted) begin
            w_speed = 16'd0;
        end else if (i_cfg.constant_mode) begin
            w_speed = i_cfg.fixed_speed;
        end else if (r_cur == r_end || w_v[50]) begin
            w_speed = 16'd0;
        end else if (w_v[49:16] != 34'd0) begin
            w_speed = 16'hFFFF;
        end else begin
            w_speed = w_v[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= '0;
            r_end    <= '0;
            r_len    <= '0;
            r_halted <= 1'b0;
        end else if (i_cmd.goal) begin
            if (r_mode == MODE_ANGLE || r_mode == MODE_TURN) begin
                r_start  <= r_cur;
                r_end    <= w_goal;
                r_len    <= w_goal - r_cur;
                r_halted <= 1'b0;
            end else if (r_mode == MODE_STOP) begin
                r_start  <= r_cur;
                r_halted <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_cur   <= i_current_position;
            r_tgt   <= i_target_angle;
            r_dir   <= i_turn_direction;
            r_turns <= i_turn_count;
        end
        if (i_cmd.ang_save) begin
            r_angle <= (r_cur[31] && w_rem[15:0] != 16'd0) ? w_s - w_rem[15:0]
                                                            : w_rem[15:0];
        end
        if (i_cmd.gmul) begin
            r_gprod <= {16'd0, w_s} * ((r_mode == MODE_ANGLE) ? {24'd0, r_turns[15:8]}
                                                              : {16'd0, r_turns});
        end
        if (i_cmd.rmul) begin
            r_pin_p  <= r_len * $signed({1'b0, i_cfg.ramp_in_fraction});
            r_pout_p <= r_len * $signed({1'b0, i_cfg.ramp_out_fraction});
            r_peak   <= 17'(({9'd0, i_cfg.top_speed} * {16'd0, i_cfg.peak_limit}) >> 8);
        end
        if (i_cmd.ramp) begin
            r_pin  <= w_pin;
            r_pout <= w_pout;
        end
        if (i_cmd.sel) begin
            r_flat <= !w_in_seg && !w_out_seg;
            r_dx   <= {r_cur[31], r_cur} - {w_a[31], w_a};
            r_db   <= {w_b[31], w_b} - {w_a[31], w_a};
            r_dy   <= $signed({1'b0, w_yb}) - $signed({1'b0, w_ya});
            r_ya   <= w_ya;
            r_yb   <= w_yb;
        end
        if (i_cmd.mmul) begin
            r_prod <= r_dx * r_dy;
        end
        if (i_cmd.fin) begin
            o_speed         <= w_speed;
            o_goal_position <= r_end;
            o_moving        <= r_cur != r_end;
            o_angle_in_turn <= r_angle;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sts.div_busy = w_busy;
    assign o_sts.out_full = r_out_valid && !i_ready;

endmodule

FILE: design/stsp_ctrl.sv
// ----------------------------------------------------------------------------
// stsp_ctrl
// Sequencer that steps the datapath through one item.
// ----------------------------------------------------------------------------
module stsp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  stsp_pkg::t_sts i_sts,
    output stsp_pkg::t_cmd o_cmd
);
    import stsp_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_valid) n_state = S_ANG_DIV;
            S_ANG_DIV:  n_state = S_ANG_WAIT;
            S_ANG_WAIT: if (!i_sts.div_busy) n_state = S_GMUL;
            S_GMUL:     n_state = S_GOAL;
            S_GOAL:     n_state = S_RMUL;
            S_RMUL:     n_state = S_RAMP;
            S_RAMP:     n_state = S_SEL;
            S_SEL:      n_state = S_MMUL;
            S_MMUL:     n_state = S_MAP_DIV;
            S_MAP_DIV:  n_state = S_MAP_WAIT;
            S_MAP_WAIT: if (!i_sts.div_busy) n_state = S_FIN;
            S_FIN:      if (!i_sts.out_full) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            S_ANG_DIV:  o_cmd.div_start = 1'b1;
            S_ANG_WAIT: o_cmd.ang_save  = !i_sts.div_busy;
            S_GMUL:     o_cmd.gmul      = 1'b1;
            S_GOAL:     o_cmd.goal      = 1'b1;
            S_RMUL:     o_cmd.rmul      = 1'b1;
            S_RAMP:     o_cmd.ramp      = 1'b1;
            S_SEL:      o_cmd.sel       = 1'b1;
            S_MMUL:     o_cmd.mmul      = 1'b1;
            S_MAP_DIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = 1'b1;
            end
            S_MAP_WAIT: o_cmd.div_sel = 1'b1;
            S_FIN:      o_cmd.fin     = !i_sts.out_full;
            default:    o_cmd = '0;
        endcase
    end

endmodule

FILE: design/stepper_trapezoid_speed_profile_unit.sv
// ----------------------------------------------------------------------------
// stepper_trapezoid_speed_profile_unit
// Trapezoidal speed-profile generator for a stepper: moves, stops and ticks.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  input     i_valid / o_ready         i_mode, i_current_position, i_target_angle,
//                                      i_turn_direction, i_turn_count
//  result    o_valid / i_ready         o_speed, o_goal_position, o_moving,
//                                      o_angle_in_turn
//  config    psel/penable/pwrite       paddr, pwdata, prdata (pready tied high)
//
//  Each item makes two passes through the bit-serial divider: angle modulo,
//  then ramp interpolation, each pass running until the divider is idle.
//  One item is in work at a time; the result register lets the next item in
//  while a result waits, and the sequencer holds in its last step on a stall.
//  Synchronous active-low reset; the config registers come up at their reset values.
// ----------------------------------------------------------------------------
module stepper_trapezoid_speed_profile_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_current_position,
    input  logic [15:0]        i_target_angle,
    input  logic signed [1:0]  i_turn_direction,
    input  logic [15:0]        i_turn_count,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_speed,
    output logic signed [31:0] o_goal_position,
    output logic               o_moving,
    output logic [15:0]        o_angle_in_turn
);
    import stsp_pkg::*;

    t_cfg r_cfg;
    t_cmd w_cmd;
    t_sts w_sts;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.steps_per_turn    <= 16'd200;
            r_cfg.ramp_in_fraction  <= 9'd0;
            r_cfg.ramp_out_fraction <= 9'd0;
            r_cfg.peak_limit        <= 9'd256;
            r_cfg.constant_mode     <= 1'b0;
            r_cfg.fixed_speed       <= 16'd0;
            r_cfg.top_speed         <= 16'd1000;
            r_cfg.floor_speed       <= 16'd100;
        end else if (w_wr) begin
            unique case (paddr[4:2])
                REG_STEPS:    r_cfg.steps_per_turn    <= pwdata[15:0];
                REG_RAMP_IN:  r_cfg.ramp_in_fraction  <= pwdata[8:0];
                REG_RAMP_OUT: r_cfg.ramp_out_fraction <= pwdata[8:0];
                REG_PEAK:     r_cfg.peak_limit        <= pwdata[8:0];
                REG_CONST:    r_cfg.constant_mode     <= pwdata[0];
                REG_FIXED:    r_cfg.fixed_speed       <= pwdata[15:0];
                REG_TOP:      r_cfg.top_speed         <= pwdata[15:0];
                REG_FLOOR:    r_cfg.floor_speed       <= pwdata[15:0];
                default:      r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_STEPS:    prdata = {16'd0, r_cfg.steps_per_turn};
            REG_RAMP_IN:  prdata = {23'd0, r_cfg.ramp_in_fraction};
            REG_RAMP_OUT: prdata = {23'd0, r_cfg.ramp_out_fraction};
            REG_PEAK:     prdata = {23'd0, r_cfg.peak_limit};
            REG_CONST:    prdata = {31'd0, r_cfg.constant_mode};
            REG_FIXED:    prdata = {16'd0, r_cfg.fixed_speed};
            REG_TOP:      prdata = {16'd0, r_cfg.top_speed};
            REG_FLOOR:    prdata = {16'd0, r_cfg.floor_speed};
            default:      prdata = 32'd0;
        endcase
    end

    stsp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    stsp_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_mode             (i_mode),
        .i_current_position (i_current_position),
        .i_target_angle     (i_target_angle),
        .i_turn_direction   (i_turn_direction),
        .i_turn_count       (i_turn_count),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_speed            (o_speed),
        .o_goal_position    (o_goal_position),
        .o_moving           (o_moving),
        .o_angle_in_turn    (o_angle_in_turn)
    );

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stepper trapezoid speed-profile unit: random and
// directed moves, stops and ticks against an in-bench profile calculator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import stsp_pkg::*;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] pos;
        logic [15:0]        angle;
        logic signed [1:0]  dir;
        logic [15:0]        turns;
    } t_cmd_item;

    typedef struct packed {
        logic [15:0]        speed;
        logic signed [31:0] goal;
        logic               moving;
        logic [15:0]        angle;
    } t_speed_item;

    logic i_clk = 0, i_rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [4:0] paddr = 0;
    logic [31:0] pwdata = 0, prdata;
    logic pready;
    logic i_valid = 0, o_ready;
    logic [1:0] i_mode = 0;
    logic signed [31:0] i_current_position = 0;
    logic [15:0] i_target_angle = 0;
    logic signed [1:0] i_turn_direction = 0;
    logic [15:0] i_turn_count = 0;
    logic o_valid, i_ready = 0;
    logic [15:0] o_speed;
    logic signed [31:0] o_goal_position;
    logic o_moving;
    logic [15:0] o_angle_in_turn;

    stepper_trapezoid_speed_profile_unit uut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // predictor state
    t_cfg cfg;
    logic [31:0] mv_start, mv_end, mv_len;
    logic mv_halted;

    t_cmd_item   pending_cmds[$];
    t_speed_item expected_speeds[$];
    int errors = 0;
    int hold_cycles = 0;
    int pos_base;

    function automatic longint eff_steps();
        return cfg.steps_per_turn == 0 ? 1 : longint'(cfg.steps_per_turn);
    endfunction

    function automatic longint angle_of(longint p);
        longint r;
        r = p % eff_steps();
        if (r < 0) r += eff_steps();
        return r;
    endfunction

    function automatic longint ramp_map(longint x, longint a, longint b,
                                        longint ya, longint yb);
        if (a == b) return yb;
        return (x - a) * (yb - ya) / (b - a) + ya;
    endfunction

    function automatic longint wrap(longint v);
        return longint'(signed'(v[31:0]));
    endfunction

    function automatic longint profile(longint cur);
        longint st, en, len, peak, lo, pin, pout, v;
        st = longint'(signed'(mv_start));
        en = longint'(signed'(mv_end));
        len = longint'(signed'(mv_len));
        peak = (longint'(cfg.top_speed) * cfg.peak_limit) >>> 8;
        lo = cfg.floor_speed;
        pin = wrap((st * 512 + len * longint'(cfg.ramp_in_fraction)) / 512);
        pout = wrap((en * 512 - len * longint'(cfg.ramp_out_fraction)) / 512);
        if (mv_halted) return 0;
        if (cfg.constant_mode) return cfg.fixed_speed;
        if (st > en) begin
            if (cur >= pin) v = ramp_map(cur, st, pin, lo, peak);
            else if (cur <= pout) v = ramp_map(cur, pout, en, peak, lo);
            else v = peak;
        end else begin
            if (cur <= pin) v = ramp_map(cur, st, pin, lo, peak);
            else if (cur >= pout) v = ramp_map(cur, pout, en, peak, lo);
            else v = peak;
        end
        if (cur == en) v = 0;
        return v;
    endfunction

    function automatic t_speed_item predict_speed(t_cmd_item c);
        t_speed_item r;
        longint cur, s, delta, rot, goal, spd;
        cur = c.pos;
        s = eff_steps();
        if (c.mode == MODE_ANGLE || c.mode == MODE_TURN) begin
            goal = cur;
            if (c.mode == MODE_ANGLE) begin
                delta = longint'(c.angle) - angle_of(cur);
                rot = c.turns >> 8;
                if (c.dir == signed'(DIR_CCW))
                    goal = cur + delta - s * (delta < 0 ? rot : rot + 1);
                else if (c.dir == signed'(DIR_NEAR))
                    goal = cur + delta + (delta < 0 ? -s * rot : s * rot);
                else if (c.dir == signed'(DIR_CW))
                    goal = cur + delta + s * (delta < 0 ? rot + 1 : rot);
            end else if (c.dir != signed'(DIR_NONE)) begin
                goal = (cur * 256 + longint'(c.dir) * s * longint'(c.turns)) / 256;
            end
            mv_start = cur[31:0];
            mv_end = goal[31:0];
            mv_len = mv_end - mv_start;
            mv_halted = 0;
        end else if (c.mode == MODE_STOP) begin
            mv_start = cur[31:0];
            mv_halted = 1;
        end
        spd = profile(cur);
        if (spd < 0) spd = 0;
        if (spd > 65535) spd = 65535;
        r.speed = spd[15:0];
        r.goal = mv_end;
        r.moving = (cur != longint'(signed'(mv_end)));
        r.angle = 16'(angle_of(cur));
        return r;
    endfunction

    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            REG_STEPS:    cfg.steps_per_turn = val[15:0];
            REG_RAMP_IN:  cfg.ramp_in_fraction = val[8:0];
            REG_RAMP_OUT: cfg.ramp_out_fraction = val[8:0];
            REG_PEAK:     cfg.peak_limit = val[8:0];
            REG_CONST:    cfg.constant_mode = val[0];
            REG_FIXED:    cfg.fixed_speed = val[15:0];
            REG_TOP:      cfg.top_speed = val[15:0];
            default:      cfg.floor_speed = val[15:0];
        endcase
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || expected_speeds.size() != 0)
            @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    function automatic t_cmd_item mk(logic [1:0] m, logic signed [31:0] p,
                                     logic [15:0] a, logic signed [1:0] d,
                                     logic [15:0] t);
        t_cmd_item c;
        c.mode = m; c.pos = p; c.angle = a; c.dir = d; c.turns = t;
        return c;
    endfunction

    function automatic int rnd_gap();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200)
                                              : $urandom_range(0, 3);
    endfunction

    // driver
    int src_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                void'(pending_cmds.pop_front());
                src_gap = rnd_gap();
            end
            if (i_valid && !o_ready) begin
                // hold
            end else if (src_gap > 0) begin
                src_gap--;
                i_valid <= 0;
            end else if (pending_cmds.size() > 0 && !(i_valid && o_ready
                         && pending_cmds.size() == 0)) begin
                expected_speeds.push_back(predict_speed(pending_cmds[0]));
                {i_mode, i_current_position, i_target_angle,
                 i_turn_direction, i_turn_count} <= pending_cmds[0];
                i_valid <= 1;
                src_gap = -1;
            end else begin
                i_valid <= 0;
            end
        end
    end

    // monitor
    int sink_gap = 0;
    always @(posedge i_clk) begin
        t_speed_item got, want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                got = {o_speed, o_goal_position, o_moving, o_angle_in_turn};
                if (expected_speeds.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected item %h", got);
                end else begin
                    want = expected_speeds.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp spd %0d goal %0d mv %0d ang %0d,",
                                     want.speed, want.goal, want.moving, want.angle,
                                     " got spd %0d goal %0d mv %0d ang %0d",
                                     got.speed, got.goal, got.moving, got.angle);
                    end
                end
                sink_gap = rnd_gap();
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_ready <= 0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                i_ready <= 0;
            end else begin
                i_ready <= 1;
            end
        end
    end

    function automatic logic signed [31:0] rnd_pos();
        case ($urandom_range(0, 3))
            0: return $urandom;
            default: return pos_base + $urandom_range(0, 4000) - 2000;
        endcase
    endfunction

    task automatic random_move_seq(int n);
        logic signed [31:0] p, g;
        t_cmd_item c;
        int k;
        p = rnd_pos();
        c = mk($urandom_range(1, 2) == 1 ? MODE_ANGLE : MODE_TURN, p,
               $urandom_range(0, 65534), $urandom, $urandom_range(0, 3) == 0 ?
               $urandom : $urandom_range(0, 1023));
        pending_cmds.push_back(c);
        // walk toward a random nearby point with ticks, now and then a stop
        g = p + $urandom_range(0, 1200) - 600;
        for (k = 0; k < n; k++) begin
            p = p + (g - p) / 4 + $urandom_range(0, 2) - 1;
            if ($urandom_range(0, 15) == 0)
                pending_cmds.push_back(mk(MODE_STOP, p, $urandom, $urandom, $urandom));
            else
                pending_cmds.push_back(mk(MODE_TICK, p, $urandom, $urandom, $urandom));
        end
    endtask

    initial begin
        int n, ph;
        cfg = '{16'd200, 9'd0, 9'd0, 9'd256, 1'b0, 16'd0, 16'd1000, 16'd100};
        mv_start = 0; mv_end = 0; mv_len = 0; mv_halted = 0;
        pos_base = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed
        cfg_write(REG_RAMP_IN, 128);
        cfg_write(REG_RAMP_OUT, 256);
        pending_cmds.push_back(mk(MODE_TICK, 0, 0, 0, 0));
        pending_cmds.push_back(mk(MODE_ANGLE, 50, 150, DIR_NEAR, 16'h0200));
        pending_cmds.push_back(mk(MODE_TICK, 60, 0, 0, 0));
        pending_cmds.push_back(mk(MODE_TICK, 300, 0, 0, 0));
        pending_cmds.push_back(mk(MODE_TICK, 550, 0, 0, 0));
        pending_cmds.push_back(mk(MODE_ANGLE, -7, 65534, DIR_CW, 16'hFFFF));
        pending_cmds.push_back(mk(MODE_ANGLE, 32'sh7FFFFFFF, 0, DIR_CCW, 16'hFF00));
        pending_cmds.push_back(mk(MODE_ANGLE, 5, 3, DIR_NONE, 16'h0100));
        pending_cmds.push_back(mk(MODE_TURN, 32'sh80000000, 0, DIR_CCW, 16'hFFFF));
        pending_cmds.push_back(mk(MODE_TURN, 100, 0, DIR_NONE, 16'h0300));
        pending_cmds.push_back(mk(MODE_TURN, 100, 0, DIR_NEAR, 16'h0300));
        pending_cmds.push_back(mk(MODE_TURN, -100, 0, DIR_CW, 16'h0080));
        pending_cmds.push_back(mk(MODE_TICK, -90, 0, 0, 0));
        pending_cmds.push_back(mk(MODE_STOP, -80, 0, 0, 0));
        pending_cmds.push_back(mk(MODE_TICK, -70, 0, 0, 0));
        pending_cmds.push_back(mk(MODE_TICK, 32'sh80000000, 16'hFFFF, DIR_CCW, 16'hFFFF));
        wait_idle();
        cfg_write(REG_STEPS, 0);
        cfg_write(REG_CONST, 1);
        cfg_write(REG_FIXED, 65535);
        cfg_write(REG_PEAK, 0);
        cfg_write(REG_TOP, 65535);
        cfg_write(REG_FLOOR, 65535);
        pending_cmds.push_back(mk(MODE_ANGLE, 9, 0, DIR_CW, 16'h0500));
        pending_cmds.push_back(mk(MODE_TICK, 9, 0, 0, 0));
        pending_cmds.push_back(mk(MODE_TURN, -1, 0, DIR_CCW, 16'h0100));
        pending_cmds.push_back(mk(MODE_TICK, -2, 0, 0, 0));
        wait_idle();

        // random phases across settings
        for (ph = 0; ph < 10; ph++) begin
            case (ph % 5)
                0: cfg_write(REG_STEPS, 65535);
                1: cfg_write(REG_STEPS, 1);
                default: cfg_write(REG_STEPS, $urandom_range(1, 2000));
            endcase
            cfg_write(REG_RAMP_IN, ph == 1 ? 0 : $urandom_range(0, 256));
            cfg_write(REG_RAMP_OUT, ph == 2 ? 256 : $urandom_range(0, 256));
            cfg_write(REG_PEAK, ph == 3 ? 256 : $urandom_range(0, 256));
            cfg_write(REG_CONST, ph == 4);
            cfg_write(REG_FIXED, $urandom);
            cfg_write(REG_TOP, ph == 5 ? 65535 : $urandom);
            cfg_write(REG_FLOOR, ph == 6 ? 0 : $urandom);
            pos_base = $urandom;
            n = 0;
            while (n < 150) begin
                if (ph == 3 && n == 0) begin
                    // long receiver hold while the source keeps offering
                    hold_cycles = 3000;
                end
                if ($urandom_range(0, 9) == 0) begin
                    pending_cmds.push_back(mk($urandom, $urandom, $urandom_range(0, 65534),
                                              $urandom, $urandom));
                    n++;
                end else begin
                    random_move_seq($urandom_range(3, 15));
                    n += 10;
                end
                while (pending_cmds.size() > 20) @(posedge i_clk);
            end
            if (ph == 5) wait_idle();
            wait_idle();
        end
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #40ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule

FILE: stepper_trapezoid_speed_profile_unit.f
design/stsp_pkg.sv
design/stsp_divider.sv
design/stsp_datapath.sv
design/stsp_ctrl.sv
design/stepper_trapezoid_speed_profile_unit.sv
test/tb.sv
